FILE: hdl/pice_pkg.sv
// ----------------------------------------------------------------------------
// pice_pkg: shared definitions for the elliptic cylinder point test
// Widths, register indexes, the quarter-wave sine table and the records
// that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pice_pkg;

   localparam int TRIG_TABLE_BITS = 10;
   localparam int TRIG_QBITS      = TRIG_TABLE_BITS - 2;
   localparam int TRIG_QUARTER    = 1 << TRIG_QBITS;
   localparam int TRIG_KW         = TRIG_TABLE_BITS - 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int PIPE_STAGES = 8;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_A = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_B = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW      = 3'd6;

   typedef logic [14:0] trig_tab_type [TRIG_QUARTER+1];

   // Magnitude of sine at quarter-turn phase k, polynomial in Q16, Q1.14 out.
   function automatic logic [14:0] trig_entry(int unsigned k);
      longint unsigned p, p2, t, u, s, v;
      p  = longint'(k) << (18 - TRIG_TABLE_BITS);
      p2 = (p * p) >> 16;
      t  = 64'd42047 - ((p2 * 64'd4640) >> 16);
      u  = 64'd102944 - ((p2 * t) >> 16);
      s  = (p * u) >> 16;
      v  = (s + 64'd2) >> 2;
      if (v > 64'd16384) begin
         v = 64'd16384;
      end
      return v[14:0];
   endfunction

   function automatic trig_tab_type build_trig_tab();
      trig_tab_type tab;
      for (int k = 0; k <= TRIG_QUARTER; k++) begin
         tab[k] = trig_entry(k);
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();

   // Signed Q1.14 sine of a table index, full turn folded onto a quarter.
   function automatic logic signed [15:0] trig_q14(logic [TRIG_TABLE_BITS-1:0] idx);
      logic [1:0]            quad;
      logic [TRIG_KW-1:0]    r;
      logic [TRIG_KW-1:0]    k;
      logic signed [15:0]    mag;
      quad = idx[TRIG_TABLE_BITS-1 -: 2];
      r    = {1'b0, idx[TRIG_QBITS-1:0]};
      k    = quad[0] ? (TRIG_KW'(TRIG_QUARTER) - r) : r;
      mag  = $signed({1'b0, TRIG_TAB[k]});
      return quad[1] ? -mag : mag;
   endfunction

   // Classified point, as queued between front and back.
   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dz;
      logic               y_ok;
   } pice_item_type;

   // Placement seen by the front end.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_z;
      logic signed [31:0] base_y;
      logic signed [32:0] top_y;
      logic               unbounded;
   } pice_place_type;

   // Shape seen by the back end.
   typedef struct packed {
      logic signed [15:0] sin_q14;
      logic signed [15:0] cos_q14;
      logic [23:0]        big_a;
      logic [23:0]        big_b;
      logic [31:0]        a_sq;
      logic [31:0]        b_sq;
   } pice_shape_type;

endpackage

FILE: hdl/pice_if.sv
// ----------------------------------------------------------------------------
// pice_if: channel interfaces of the elliptic cylinder point test
// Point channel, result channel and register write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface pice_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

interface pice_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, output hit, input ready);
   modport sink   (input valid, input hit, output ready);
endinterface

interface pice_csr_if import pice_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [31:0]            data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pice_csr.sv
// ----------------------------------------------------------------------------
// pice_csr: configuration registers
// Holds the cylinder registers and derives the placement for the front end
// and the registered sine, cosine and squared radii for the back end.
// ----------------------------------------------------------------------------
module pice_csr import pice_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output logic                   csr_ready,
   output pice_place_type         place,
   output pice_shape_type         shape
);

   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [15:0]        radius_a_ff, radius_b_ff, height_ff, yaw_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic [31:0]        a_sq_ff, b_sq_ff;
   logic [15:0]        radius_b_eff;
   logic [TRIG_TABLE_BITS-1:0] sin_idx, cos_idx;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_a_ff <= '0;
         radius_b_ff <= '0;
         height_ff   <= '0;
         yaw_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_CENTER_Z: center_z_ff <= csr_data;
            CSR_RADIUS_A: radius_a_ff <= csr_data[15:0];
            CSR_RADIUS_B: radius_b_ff <= csr_data[15:0];
            CSR_HEIGHT:   height_ff   <= csr_data[15:0];
            CSR_YAW:      yaw_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign radius_b_eff = (radius_b_ff != 16'd0) ? radius_b_ff : radius_a_ff;
   assign sin_idx      = yaw_ff[15 -: TRIG_TABLE_BITS];
   assign cos_idx      = sin_idx + TRIG_TABLE_BITS'(TRIG_QUARTER);

   // Derived shape terms are only consumed a stage after the queue.
   always_ff @(posedge clock) begin
      sin_ff  <= trig_q14(sin_idx);
      cos_ff  <= trig_q14(cos_idx);
      a_sq_ff <= 32'(radius_a_ff) * 32'(radius_a_ff);
      b_sq_ff <= 32'(radius_b_eff) * 32'(radius_b_eff);
   end

   assign place.center_x  = center_x_ff;
   assign place.center_z  = center_z_ff;
   assign place.base_y    = center_y_ff;
   assign place.top_y     = 33'(center_y_ff) + $signed({9'b0, height_ff, 8'b0});
   assign place.unbounded = (height_ff == 16'd0);

   assign shape.sin_q14 = sin_ff;
   assign shape.cos_q14 = cos_ff;
   assign shape.big_a   = {radius_a_ff, 8'b0};
   assign shape.big_b   = {radius_b_eff, 8'b0};
   assign shape.a_sq    = a_sq_ff;
   assign shape.b_sq    = b_sq_ff;

endmodule

FILE: hdl/pice_front.sv
// ----------------------------------------------------------------------------
// pice_front: point intake and classification
// Takes a point, forms its offset from the centre and settles the vertical
// bounds test before the item is queued.
// ----------------------------------------------------------------------------
module pice_front import pice_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   input  pice_place_type     place,
   input  logic               q_full,
   output logic               q_push,
   output pice_item_type      q_item
);

   logic above_base, below_top;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign above_base = point_y > place.base_y;
   assign below_top  = place.top_y > 33'(point_y);

   assign q_item.dx   = 33'(point_x) - 33'(place.center_x);
   assign q_item.dz   = 33'(point_z) - 33'(place.center_z);
   assign q_item.y_ok = above_base && (place.unbounded || below_top);

endmodule

FILE: hdl/pice_queue.sv
// ----------------------------------------------------------------------------
// pice_queue: small queue between front and back
// Lets intake continue while the back end is stalled by the receiver.
// ----------------------------------------------------------------------------
module pice_queue import pice_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pice_item_type push_item,
   output logic          full,
   input  logic          pop,
   output pice_item_type pop_item,
   output logic          not_empty
);

   pice_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && not_empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && not_empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && not_empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/pice_back.sv
// ----------------------------------------------------------------------------
// pice_back: rotation and ellipse test pipeline
// Eight stages: rotate, scale down, bound checks, squares, margin, partial
// products, product sums and the final compare in the output register.
// ----------------------------------------------------------------------------
module pice_back import pice_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  pice_item_type  item,
   input  logic           item_valid,
   output logic           pop,
   input  pice_shape_type shape,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_hit
);

   logic [PIPE_STAGES:1] vld_ff;
   logic                 advance;

   logic signed [48:0] m_cx_ff, m_sz_ff, m_sx_ff, m_cz_ff;
   logic               ok1_ff, ok2_ff, ok3_ff, ok4_ff, ok5_ff, ok6_ff, ok7_ff;
   logic signed [49:0] x_full, z_full;
   logic signed [35:0] xl_ff, zl_ff;
   logic [35:0]        ax, az;
   logic [23:0]        ax_ff, az_ff;
   logic [47:0]        ax_sq_ff, az_sq_ff, az_sq5_ff, diff_ff;
   logic [63:0]        l_lo_ff, r_lo_ff;
   logic [47:0]        l_hi_ff, r_hi_ff;
   logic [79:0]        lhs_ff, rhs_ff;
   logic               hit_ff;

   // The whole pipe moves together unless the output register is held.
   assign advance   = !vld_ff[PIPE_STAGES] || rsp_ready;
   assign pop       = advance && item_valid;
   assign rsp_valid = vld_ff[PIPE_STAGES];
   assign rsp_hit   = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_STAGES-1:1], pop};
      end
   end

   assign x_full = 50'(m_cx_ff) - 50'(m_sz_ff);
   assign z_full = 50'(m_sx_ff) + 50'(m_cz_ff);
   assign ax     = xl_ff[35] ? 36'(-xl_ff) : 36'(xl_ff);
   assign az     = zl_ff[35] ? 36'(-zl_ff) : 36'(zl_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         // Rotation by minus the yaw.
         m_cx_ff <= 49'(shape.cos_q14) * 49'(item.dx);
         m_sz_ff <= 49'(shape.sin_q14) * 49'(item.dz);
         m_sx_ff <= 49'(shape.sin_q14) * 49'(item.dx);
         m_cz_ff <= 49'(shape.cos_q14) * 49'(item.dz);
         ok1_ff  <= item.y_ok;
         // Floor division by 2^14.
         xl_ff  <= $signed(x_full[49:14]);
         zl_ff  <= $signed(z_full[49:14]);
         ok2_ff <= ok1_ff;
         // Bounding box; past here both magnitudes fit in 24 bits.
         ax_ff  <= ax[23:0];
         az_ff  <= az[23:0];
         ok3_ff <= ok2_ff && (ax < {12'b0, shape.big_a}) && (az < {12'b0, shape.big_b});
         ax_sq_ff <= 48'(ax_ff) * 48'(ax_ff);
         az_sq_ff <= 48'(az_ff) * 48'(az_ff);
         ok4_ff   <= ok3_ff;
         diff_ff   <= {shape.a_sq, 16'b0} - ax_sq_ff;
         az_sq5_ff <= az_sq_ff;
         ok5_ff    <= ok4_ff;
         // The common factor 2^16 of A^2 and B^2 is dropped from both sides.
         l_lo_ff <= 64'(az_sq5_ff[31:0]) * 64'(shape.a_sq);
         l_hi_ff <= 48'(az_sq5_ff[47:32]) * 48'(shape.a_sq);
         r_lo_ff <= 64'(diff_ff[31:0]) * 64'(shape.b_sq);
         r_hi_ff <= 48'(diff_ff[47:32]) * 48'(shape.b_sq);
         ok6_ff  <= ok5_ff;
         lhs_ff <= {16'b0, l_lo_ff} + {l_hi_ff, 32'b0};
         rhs_ff <= {16'b0, r_lo_ff} + {r_hi_ff, 32'b0};
         ok7_ff <= ok6_ff;
         hit_ff <= ok7_ff && (lhs_ff < rhs_ff);
      end
   end

endmodule

FILE: hdl/point_in_elliptic_cylinder.sv
// ----------------------------------------------------------------------------
// point_in_elliptic_cylinder: point inside a yawed elliptic cylinder
// Tests signed Q24.8 points against a vertical elliptic cylinder set up
// through a register write channel.
// ----------------------------------------------------------------------------
// Usage notes.
// The req channel carries one point per beat (point_x, point_y, point_z).
// The rsp channel returns one beat per point, in order, with hit set when
// the point lies strictly inside the cylinder.
// The csr channel writes one register per beat (index 0..6: center_x,
// center_y, center_z, radius_a, radius_b, height, yaw); it is always ready
// and an index outside that list is dropped. Write it only while no point
// is in flight.
// A point passes through the four-entry queue and the eight back-end stages,
// the last of which is the output register.
// Throughput is one point per cycle while the receiver takes results, set by
// the back-end pipeline, which holds at most one point per stage.
// Reset clears the registers to zero, empties the queue and drops any
// result in flight. When the receiver stalls, the back end holds in place
// and the queue keeps taking points until its four entries are full.
// ----------------------------------------------------------------------------
module point_in_elliptic_cylinder import pice_pkg::*; (
   input logic        clock,
   input logic        reset,
   pice_req_if.sink   req,
   pice_rsp_if.source rsp,
   pice_csr_if.sink   csr
);

   pice_place_type place;
   pice_shape_type shape;
   pice_item_type  push_item;
   pice_item_type  pop_item;
   logic           q_full;
   logic           q_push;
   logic           q_pop;
   logic           q_not_empty;
   logic           csr_ready;
   logic           req_ready;
   logic           rsp_valid;
   logic           rsp_hit;

   // Register file and the terms derived from it.
   pice_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr.valid),
      .csr_index (csr.index),
      .csr_data  (csr.data),
      .csr_ready (csr_ready),
      .place     (place),
      .shape     (shape)
   );

   // Front end: offsets and the vertical test, at the rate of the req beats.
   pice_front u_front (
      .req_valid (req.valid),
      .req_ready (req_ready),
      .point_x   (req.point_x),
      .point_y   (req.point_y),
      .point_z   (req.point_z),
      .place     (place),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // The queue decouples intake from a stalled back end.
   pice_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .not_empty (q_not_empty)
   );

   // Back end: rotation and the exact ellipse compare.
   pice_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (pop_item),
      .item_valid (q_not_empty),
      .pop        (q_pop),
      .shape      (shape),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp.ready),
      .rsp_hit    (rsp_hit)
   );

   assign csr.ready = csr_ready;
   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign rsp.hit   = rsp_hit;

endmodule

FILE: hdl/pice_checker.sv
// ----------------------------------------------------------------------------
// pice_checker: port-level checks for the cylinder point test
// Tracks points in flight and checks results against that count.
// ----------------------------------------------------------------------------
module pice_checker import pice_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   localparam int MAX_PEND = QUEUE_DEPTH + PIPE_STAGES;
   localparam int PEND_W   = $clog2(MAX_PEND + 1) + 1;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              took, gave;

   assign took = req_valid && req_ready;
   assign gave = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (took && !gave) begin
         pend_in = pend_ff + 1'b1;
      end else if (!took && gave) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled result beat changed or vanished");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result beat without a point in flight");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_W'(MAX_PEND))
      else $error("more points in flight than queue and pipe can hold");

endmodule

bind point_in_elliptic_cylinder pice_checker u_pice_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_hit   (rsp.hit)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the elliptic cylinder point test
// Drives points through the request channel and sets up the cylinder through
// the register channel. Each response beat is checked against a hit flag
// predicted in the bench from the cylinder setup and the point.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pice_pkg::*;

   // Index past the end of the register list. A write here must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   localparam logic signed [31:0] Q_MAX = 32'h7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'h8000_0000;

   localparam longint ONE_Q14     = 16384;
   localparam int     CYCLE_LIMIT = 200_000;
   localparam int     DRAIN_WAIT  = 12;

   // Cylinder setup as the bench believes the block holds it.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [15:0]        radius_a;
      logic [15:0]        radius_b;
      logic [15:0]        height;
      logic [15:0]        yaw;
   } shape_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } probe_point_type;

   // How the expected hit of a directed row is found: typed in, or predicted.
   typedef enum logic [1:0] {WANT_MODEL, WANT_MISS, WANT_HIT} hit_want_type;

   typedef struct packed {
      logic [2:0]         slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      hit_want_type       want;
   } probe_row_type;

   // Cylinder setups for the directed part. Slot 0 is the state after reset,
   // so it is never written; all the others are loaded when a row asks.
   localparam shape_type SHAPES [5] = '{
      '{32'sd0, 32'sd0, 32'sd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{32'sd0, 32'sd0, 32'sd0, 16'd10, 16'd0, 16'd0, 16'd0},
      '{32'sd0, 32'sd0, 32'sd0, 16'd10, 16'd4, 16'd5, 16'd0},
      '{Q_MAX, Q_MIN, Q_MIN, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
      '{32'sd1280, -32'sd256, 32'sd0, 16'd20, 16'd3, 16'd0, 16'd16384}
   };

   // Directed points. Coordinates are Q24.8, so 2560 is ten whole units.
   localparam probe_row_type PROBES [24] = '{
      // Reset state: both radii are zero, so nothing can be inside.
      '{3'd0, 32'sd0, 32'sd1, 32'sd0, WANT_MISS},
      '{3'd0, Q_MAX, Q_MAX, Q_MAX, WANT_MISS},
      '{3'd0, Q_MIN, Q_MIN, Q_MIN, WANT_MISS},
      // Circle of radius ten, no yaw, no upper bound. Radius B is zero, so
      // radius A stands for it along Z as well.
      '{3'd1, 32'sd0, 32'sd1, 32'sd0, WANT_HIT},
      '{3'd1, 32'sd0, 32'sd0, 32'sd0, WANT_MISS},
      '{3'd1, 32'sd2560, 32'sd1, 32'sd0, WANT_MISS},
      '{3'd1, -32'sd2560, 32'sd1, 32'sd0, WANT_MISS},
      '{3'd1, 32'sd2559, 32'sd1, 32'sd0, WANT_HIT},
      '{3'd1, 32'sd0, 32'sd1, 32'sd2560, WANT_MISS},
      '{3'd1, 32'sd0, 32'sd1, -32'sd2559, WANT_HIT},
      '{3'd1, 32'sd0, Q_MAX, 32'sd0, WANT_HIT},
      '{3'd1, Q_MIN, 32'sd1, 32'sd0, WANT_MISS},
      '{3'd1, 32'sd0, 32'sd1, Q_MAX, WANT_MISS},
      '{3'd1, 32'sd1810, 32'sd1, 32'sd1810, WANT_MODEL},
      // Ellipse ten by four, five units tall: top face and Z boundary.
      '{3'd2, 32'sd0, 32'sd1279, 32'sd0, WANT_HIT},
      '{3'd2, 32'sd0, 32'sd1280, 32'sd0, WANT_MISS},
      '{3'd2, 32'sd0, 32'sd1, 32'sd1024, WANT_MISS},
      '{3'd2, 32'sd0, 32'sd1, 32'sd1023, WANT_HIT},
      '{3'd2, 32'sd2000, 32'sd640, 32'sd800, WANT_MODEL},
      // Every register at an extreme.
      '{3'd3, Q_MAX, Q_MIN, Q_MIN, WANT_MODEL},
      '{3'd3, Q_MIN, Q_MAX, Q_MAX, WANT_MODEL},
      '{3'd3, 32'sd0, 32'sd0, 32'sd0, WANT_MODEL},
      // Quarter turn of yaw with an offset centre.
      '{3'd4, 32'sd1792, 32'sd0, 32'sd0, WANT_MODEL},
      '{3'd4, 32'sd1280, -32'sd255, -32'sd500, WANT_MODEL}
   };

   logic clock;
   logic reset;

   pice_req_if req_bus ();
   pice_rsp_if rsp_bus ();
   pice_csr_if csr_bus ();

   point_in_elliptic_cylinder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Expected hit flags, oldest first, one per accepted request beat.
   bit        pending_hits [$];
   shape_type active_shape;
   int        error_count;
   int        cycle_count;
   int        tx_idle_pct;
   int        rx_stall_pct;

   always #5 clock = ~clock;

   // Signed Q1.14 sine of a yaw table index. The quarter-wave polynomial runs
   // in Q16 with every division floored, and the other three quarters come
   // from mirroring and negation.
   function automatic longint sine_q14(int unsigned turn_idx);
      int unsigned     quadrant;
      int unsigned     step;
      longint unsigned p, p2, t, u, s, v;
      quadrant = (turn_idx >> (TRIG_TABLE_BITS - 2)) & 3;
      step     = turn_idx & ((1 << (TRIG_TABLE_BITS - 2)) - 1);
      p        = longint'(step) << (18 - TRIG_TABLE_BITS);
      if ((quadrant & 1) != 0) begin
         p = 65536 - p;
      end
      p2 = (p * p) >> 16;
      t  = 42047 - ((p2 * 4640) >> 16);
      u  = 102944 - ((p2 * t) >> 16);
      s  = (p * u) >> 16;
      v  = (s + 2) >> 2;
      if (v > ONE_Q14) begin
         v = ONE_Q14;
      end
      return ((quadrant & 2) != 0) ? -longint'(v) : longint'(v);
   endfunction

   // Hit flag for one point against a cylinder setup. The point is moved to
   // the centre, turned back by the yaw, and the ellipse test is done on
   // exact wide products so that boundary points come out as misses.
   function automatic bit cylinder_hit(shape_type sh, probe_point_type pt);
      int unsigned  idx;
      longint       sn, cs, dx, dz, xl, zl, ax, az;
      longint       big_a, big_b, base_y, top_y, py;
      logic [127:0] lhs, rhs;
      idx    = sh.yaw >> (16 - TRIG_TABLE_BITS);
      sn     = sine_q14(idx);
      cs     = sine_q14(idx + (1 << (TRIG_TABLE_BITS - 2)));
      dx     = longint'($signed(pt.x)) - longint'($signed(sh.center_x));
      dz     = longint'($signed(pt.z)) - longint'($signed(sh.center_z));
      xl     = (cs * dx - sn * dz) >>> 14;
      zl     = (sn * dx + cs * dz) >>> 14;
      ax     = (xl < 0) ? -xl : xl;
      az     = (zl < 0) ? -zl : zl;
      big_a  = longint'(sh.radius_a) << 8;
      big_b  = longint'((sh.radius_b != 0) ? sh.radius_b : sh.radius_a) << 8;
      base_y = longint'($signed(sh.center_y));
      top_y  = base_y + (longint'(sh.height) << 8);
      py     = longint'($signed(pt.y));
      if (ax >= big_a || az >= big_b || py <= base_y) begin
         return 1'b0;
      end
      lhs = 128'(az * az) * 128'(big_a * big_a);
      rhs = 128'(big_b * big_b) * 128'(big_a * big_a - ax * ax);
      if (lhs >= rhs) begin
         return 1'b0;
      end
      return (sh.height == 0) || (top_y > py);
   endfunction

   // Random cylinder: mostly small and near the origin so that hits are
   // common, now and then with full-range centres, radii and heights.
   function automatic shape_type random_shape();
      shape_type sh;
      bit        wide;
      wide        = ($urandom_range(0, 5) == 0);
      sh.center_x = wide ? $urandom : $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      sh.center_y = wide ? $urandom : $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      sh.center_z = wide ? $urandom : $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      sh.radius_a = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 160));
      case ($urandom_range(0, 3))
         0: sh.radius_b = 16'd0;
         1: sh.radius_b = 16'($urandom);
         default: sh.radius_b = 16'($urandom_range(1, 160));
      endcase
      case ($urandom_range(0, 5))
         0, 1: sh.height = 16'd0;
         2: sh.height = 16'($urandom);
         default: sh.height = 16'($urandom_range(1, 200));
      endcase
      sh.yaw = 16'($urandom);
      return sh;
   endfunction

   // Random point: four in five land around the current cylinder, the rest
   // anywhere in the 32-bit space.
   function automatic probe_point_type random_point();
      probe_point_type pt;
      longint          reach, span_y;
      if ($urandom_range(0, 4) == 0) begin
         pt.x = $urandom;
         pt.y = $urandom;
         pt.z = $urandom;
         return pt;
      end
      reach  = longint'((active_shape.radius_a > active_shape.radius_b) ?
                        active_shape.radius_a : active_shape.radius_b) * 320 + 64;
      span_y = (active_shape.height == 0) ? 65536
                                          : (longint'(active_shape.height) << 8) + 128;
      pt.x = 32'(longint'($signed(active_shape.center_x))
                 + longint'($urandom_range(0, int'(2 * reach))) - reach);
      pt.z = 32'(longint'($signed(active_shape.center_z))
                 + longint'($urandom_range(0, int'(2 * reach))) - reach);
      pt.y = 32'(longint'($signed(active_shape.center_y))
                 + longint'($urandom_range(0, int'(span_y))) - 64);
      return pt;
   endfunction

   // One register write beat. The bench copy of the setup follows the write
   // only once the beat is accepted; an unknown index leaves it untouched.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_CENTER_X: active_shape.center_x = value;
         CSR_CENTER_Y: active_shape.center_y = value;
         CSR_CENTER_Z: active_shape.center_z = value;
         CSR_RADIUS_A: active_shape.radius_a = value[15:0];
         CSR_RADIUS_B: active_shape.radius_b = value[15:0];
         CSR_HEIGHT:   active_shape.height   = value[15:0];
         CSR_YAW:      active_shape.yaw      = value[15:0];
         default: ;
      endcase
   endtask

   // Loads a whole setup back to back. The 16-bit registers get random junk
   // in their upper half, which the block has to drop, and a write to the
   // unused index follows, which must change nothing.
   task automatic load_shape(input shape_type target);
      write_reg(CSR_CENTER_X, target.center_x);
      write_reg(CSR_CENTER_Y, target.center_y);
      write_reg(CSR_CENTER_Z, target.center_z);
      write_reg(CSR_RADIUS_A, {16'($urandom), target.radius_a});
      write_reg(CSR_RADIUS_B, {16'($urandom), target.radius_b});
      write_reg(CSR_HEIGHT,   {16'($urandom), target.height});
      write_reg(CSR_YAW,      {16'($urandom), target.yaw});
      write_reg(CSR_UNUSED,   $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   // One request beat, at times with a random idle gap in front of it. Valid stays
   // high after the beat so that back-to-back points need no extra step;
   // the expected hit is queued at the edge where the beat is taken.
   task automatic send_point(input probe_point_type pt, input hit_want_type want);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.point_x <= pt.x;
      req_bus.point_y <= pt.y;
      req_bus.point_z <= pt.z;
      do @(posedge clock); while (!req_bus.ready);
      pending_hits.push_back((want == WANT_MODEL) ? cylinder_hit(active_shape, pt)
                                                  : (want == WANT_HIT));
   endtask

   // Stops sending and waits until every point in flight has come back, so
   // that the block is idle for a register change or for the end of the run.
   task automatic drain_points();
      req_bus.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   // Response side: checks each accepted beat against the oldest expected
   // flag, then decides whether to stall on the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_hits.size() == 0) begin
               $display("%0t: response beat with nothing pending, actual hit %0b",
                        $time, rsp_bus.hit);
               error_count++;
            end else begin
               if (rsp_bus.hit !== pending_hits[0]) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, pending_hits[0], rsp_bus.hit);
                  error_count++;
               end
               pending_hits.delete(0);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d results outstanding",
                  $time, CYCLE_LIMIT, pending_hits.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : run_stimulus
      int unsigned     slot_now;
      probe_point_type pt;
      shape_type       target;

      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_CENTER_X;
      csr_bus.data    = '0;
      active_shape    = SHAPES[0];
      error_count     = 0;
      cycle_count     = 0;
      slot_now        = 0;

      // First stretch: the sender idles now and then, the receiver often.
      tx_idle_pct  = 24;
      rx_stall_pct = 45;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. A change of slot drains the pipe and loads the setup.
      foreach (PROBES[i]) begin
         if (PROBES[i].slot != slot_now) begin
            drain_points();
            slot_now = PROBES[i].slot;
            load_shape(SHAPES[slot_now]);
         end
         pt = '{PROBES[i].x, PROBES[i].y, PROBES[i].z};
         send_point(pt, PROBES[i].want);
      end

      // Random part in three stretches: the sender idles less than the
      // receiver stalls, then the reverse, then both run flat out. Each
      // stretch walks eight setups of forty points; the first setup of each of the
      // first two stretches is fixed, that of the first at the extremes of the registers.
      for (int stretch = 0; stretch < 3; stretch++) begin
         tx_idle_pct  = (stretch == 0) ? 24 : (stretch == 1) ? 45 : 0;
         rx_stall_pct = (stretch == 0) ? 45 : (stretch == 1) ? 24 : 0;
         for (int setup = 0; setup < 8; setup++) begin
            drain_points();
            target = random_shape();
            if (setup == 0 && stretch == 0) begin
               target = SHAPES[3];
            end
            if (setup == 0 && stretch == 1) begin
               target = '{Q_MIN, 32'sd0, Q_MIN, 16'd1, 16'hffff, 16'd1, 16'h8000};
            end
            load_shape(target);
            repeat (40) send_point(random_point(), WANT_MODEL);
         end
      end

      // Let the last results come back, then give the pipe time to show any
      // stray beat before the verdict.
      drain_points();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_hits.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_hits.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/pice_pkg.sv
hdl/pice_if.sv
hdl/pice_csr.sv
hdl/pice_front.sv
hdl/pice_queue.sv
hdl/pice_back.sv
hdl/point_in_elliptic_cylinder.sv
hdl/pice_checker.sv
tb/sv/tb.sv
